FILE: rtl/uv_phase_angle_defines.svh
`ifndef UV_PHASE_ANGLE_DEFINES_SVH
`define UV_PHASE_ANGLE_DEFINES_SVH

// Same-cycle check: whenever ante holds, cons must hold too.
`define UVPA_ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uv_phase_angle: same-cycle check failed");

// Next-cycle check: whenever ante holds, cons must hold in the next cycle.
`define UVPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uv_phase_angle: next-cycle check failed");

`endif

FILE: rtl/uvpa_pkg.sv
`default_nettype none

package uvpa_pkg;

  // Defaults for the top-level parameters
  localparam int ITERATIONS_DEF       = 16;
  localparam int CENTER_FRAC_BITS_DEF = 4;
  localparam int ANGLE_FRAC_BITS_DEF  = 13;

  // Fixed formats
  localparam int ANG_Q         = 30;  // internal angle fraction bits
  localparam int PRESCALE_BITS = 24;  // left shift of the differences
  localparam int D_W           = 26;  // signed difference, covers CENTER_FRAC_BITS <= 8
  localparam int XY_W          = D_W + PRESCALE_BITS + 2;  // room for CORDIC gain
  localparam int Z_W           = 35;  // signed Q.30 angle, covers +/- 4pi
  localparam int PHASE_W       = 16;

  localparam logic signed [Z_W-1:0] PI_Q30      = Z_W'(64'd3373259426);
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'd1686629713);
  localparam logic signed [Z_W-1:0] TWO_PI_Q30  = Z_W'(64'd6746518852);

  // Exact axis angles, used when no micro-rotation is needed
  typedef enum logic [1:0] {
    QUAD_ZERO,
    QUAD_HALF_PI,
    QUAD_PI,
    QUAD_THREE_HALF_PI
  } quad_t;

  // One item in flight through the rotation pipeline
  typedef struct packed {
    logic                   valid;
    logic                   byp;    // axis case, angle given by quad
    quad_t                  quad;
    logic                   pi_add; // vector was folded into the right half plane
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // atan(2^-i) in Q.30
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(64'd843314857);
      1:  v = Z_W'(64'd497837829);
      2:  v = Z_W'(64'd263043837);
      3:  v = Z_W'(64'd133525159);
      4:  v = Z_W'(64'd67021687);
      5:  v = Z_W'(64'd33543516);
      6:  v = Z_W'(64'd16775851);
      7:  v = Z_W'(64'd8388437);
      8:  v = Z_W'(64'd4194283);
      9:  v = Z_W'(64'd2097149);
      10: v = Z_W'(64'd1048576);
      11: v = Z_W'(64'd524288);
      12: v = Z_W'(64'd262144);
      13: v = Z_W'(64'd131072);
      14: v = Z_W'(64'd65536);
      15: v = Z_W'(64'd32768);
      16: v = Z_W'(64'd16384);
      17: v = Z_W'(64'd8192);
      18: v = Z_W'(64'd4096);
      19: v = Z_W'(64'd2048);
      20: v = Z_W'(64'd1024);
      21: v = Z_W'(64'd512);
      22: v = Z_W'(64'd256);
      23: v = Z_W'(64'd128);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Largest output code: full turn in the output format, capped at 16 bits
  function automatic logic [PHASE_W-1:0] top_code(input int afb);
    logic [63:0] raw;
    raw = 64'(TWO_PI_Q30) >> (ANG_Q - afb);
    if (raw > 64'hFFFF) begin
      raw = 64'hFFFF;
    end
    return raw[PHASE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/uvpa_prep.sv
`default_nettype none
`include "uv_phase_angle_defines.svh"

// Two stages: center subtraction, then axis detection, half-plane fold and prescale.
module uvpa_prep #(
  parameter int CENTER_FRAC_BITS = uvpa_pkg::CENTER_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [31:0]       packed_uv,
  input  wire logic [19:0]       u_center,
  input  wire logic [19:0]       v_center,
  output uvpa_pkg::cordic_t      out
);

  localparam int D_W  = uvpa_pkg::D_W;
  localparam int XY_W = uvpa_pkg::XY_W;

  logic                  a_valid;
  logic signed [D_W-1:0] du;
  logic signed [D_W-1:0] dv;
  logic signed [D_W-1:0] du_next;
  logic signed [D_W-1:0] dv_next;

  // Stage A: differences with CENTER_FRAC_BITS fraction bits
  always_comb begin
    du_next = $signed(D_W'(packed_uv[31:16]) << CENTER_FRAC_BITS) - $signed(D_W'(u_center));
    dv_next = $signed(D_W'(packed_uv[15:0]) << CENTER_FRAC_BITS) - $signed(D_W'(v_center));
  end

  always_ff @(posedge clk) begin
    du <= du_next;
    dv <= dv_next;
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  // Stage B: axis cases, fold x < 0 into the right half plane, scale up
  uvpa_pkg::cordic_t      b_next;
  logic signed [D_W-1:0]  xf;
  logic signed [D_W-1:0]  yf;
  logic signed [XY_W-1:0] x_ext;
  logic signed [XY_W-1:0] y_ext;

  always_comb begin
    xf = dv[D_W-1] ? -dv : dv;
    yf = dv[D_W-1] ? -du : du;
    x_ext = {{(XY_W-D_W){xf[D_W-1]}}, xf};
    y_ext = {{(XY_W-D_W){yf[D_W-1]}}, yf};

    b_next.valid  = a_valid;
    b_next.pi_add = dv[D_W-1];
    b_next.x      = x_ext <<< uvpa_pkg::PRESCALE_BITS;
    b_next.y      = y_ext <<< uvpa_pkg::PRESCALE_BITS;
    b_next.z      = '0;
    b_next.byp    = 1'b1;
    b_next.quad   = uvpa_pkg::QUAD_ZERO;
    if (du == '0 && dv == '0) begin
      b_next.quad = uvpa_pkg::QUAD_ZERO;
    end else if (du == '0) begin
      b_next.quad = dv[D_W-1] ? uvpa_pkg::QUAD_PI : uvpa_pkg::QUAD_ZERO;
    end else if (dv == '0) begin
      b_next.quad = du[D_W-1] ? uvpa_pkg::QUAD_THREE_HALF_PI : uvpa_pkg::QUAD_HALF_PI;
    end else begin
      b_next.byp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out <= '0;
    end else begin
      out <= b_next;
    end
  end

  `UVPA_ASSERT_NEXT(a_prep_fill, clk, rst, in_valid, a_valid)
  `UVPA_ASSERT_HOLDS(a_prep_fold, clk, rst, out.valid && !out.byp, !out.x[XY_W-1])

endmodule

`default_nettype wire

FILE: rtl/uvpa_cordic_stage.sv
`default_nettype none

// One vectoring micro-rotation, registered.
module uvpa_cordic_stage #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  uvpa_pkg::cordic_t      in,
  output uvpa_pkg::cordic_t      out
);

  uvpa_pkg::cordic_t                      rot_next;
  logic signed [uvpa_pkg::XY_W-1:0]       xs;
  logic signed [uvpa_pkg::XY_W-1:0]       ys;

  // Rotate toward the x axis; arithmetic shifts round toward minus infinity
  always_comb begin
    xs = in.x >>> STAGE;
    ys = in.y >>> STAGE;
    rot_next = in;
    if (!in.y[uvpa_pkg::XY_W-1]) begin
      rot_next.x = in.x + ys;
      rot_next.y = in.y - xs;
      rot_next.z = in.z + uvpa_pkg::atan_q30(STAGE);
    end else begin
      rot_next.x = in.x - ys;
      rot_next.y = in.y + xs;
      rot_next.z = in.z - uvpa_pkg::atan_q30(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out <= '0;
    end else begin
      out <= rot_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uvpa_finish.sv
`default_nettype none
`include "uv_phase_angle_defines.svh"

// Two stages: unwrap to [0, 2pi), then round to the output format and saturate.
module uvpa_finish #(
  parameter int ANGLE_FRAC_BITS = uvpa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  uvpa_pkg::cordic_t                  in,
  output logic                               done,
  output logic [uvpa_pkg::PHASE_W-1:0]       phase
);

  localparam int Z_W = uvpa_pkg::Z_W;
  localparam int SH  = uvpa_pkg::ANG_Q - ANGLE_FRAC_BITS;
  localparam logic [Z_W-1:0] ROUND_HALF = Z_W'(1) << (SH - 1);
  localparam logic [Z_W-1:0] TOP = Z_W'(uvpa_pkg::top_code(ANGLE_FRAC_BITS));

  logic                  t_valid;
  logic signed [Z_W-1:0] total;
  logic signed [Z_W-1:0] total_next;
  logic signed [Z_W-1:0] sum;
  logic signed [Z_W-1:0] sum_wrap;

  // Stage T: add the fold offset, wrap negatives by one turn, or take the axis angle
  always_comb begin
    sum      = (in.pi_add ? uvpa_pkg::PI_Q30 : '0) + in.z;
    sum_wrap = sum + uvpa_pkg::TWO_PI_Q30;
    total_next = sum[Z_W-1] ? sum_wrap : sum;
    if (in.byp) begin
      case (in.quad)
        uvpa_pkg::QUAD_ZERO:          total_next = '0;
        uvpa_pkg::QUAD_HALF_PI:       total_next = uvpa_pkg::HALF_PI_Q30;
        uvpa_pkg::QUAD_PI:            total_next = uvpa_pkg::PI_Q30;
        uvpa_pkg::QUAD_THREE_HALF_PI:
          total_next = uvpa_pkg::PI_Q30 + uvpa_pkg::HALF_PI_Q30;
        default:                      total_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total <= total_next;
    if (rst) begin
      t_valid <= 1'b0;
    end else begin
      t_valid <= in.valid;
    end
  end

  // Stage R: round half up, clamp at the top code
  logic [Z_W-1:0]                  rounded;
  logic [uvpa_pkg::PHASE_W-1:0]    phase_next;

  always_comb begin
    rounded = ($unsigned(total) + ROUND_HALF) >> SH;
    if (rounded > TOP) begin
      phase_next = TOP[uvpa_pkg::PHASE_W-1:0];
    end else begin
      phase_next = rounded[uvpa_pkg::PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    phase <= phase_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= t_valid;
    end
  end

  `UVPA_ASSERT_HOLDS(a_fin_range, clk, rst, t_valid, !total[Z_W-1] && (total < uvpa_pkg::TWO_PI_Q30))

endmodule

`default_nettype wire

FILE: rtl/uv_phase_angle.sv
// Throughput: one item per cycle; two prep stages, one stage per micro-rotation,
// then unwrap and rounding stages, each item independent of the others.
// busy is always low and results cannot be held off by the receiver.
// Reset (rst, synchronous) clears the valid bits and the rotation stage registers.
`default_nettype none
`include "uv_phase_angle_defines.svh"

module uv_phase_angle #(
  parameter int ITERATIONS       = uvpa_pkg::ITERATIONS_DEF,
  parameter int CENTER_FRAC_BITS = uvpa_pkg::CENTER_FRAC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS  = uvpa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [31:0]                   packed_uv,
  input  wire logic [19:0]                   u_center,
  input  wire logic [19:0]                   v_center,
  output logic                               done,
  output logic [uvpa_pkg::PHASE_W-1:0]       phase
);

  uvpa_pkg::cordic_t stg [0:ITERATIONS];

  // Fully pipelined, never stalls
  assign busy = 1'b0;

  uvpa_prep #(
    .CENTER_FRAC_BITS(CENTER_FRAC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .packed_uv(packed_uv),
    .u_center (u_center),
    .v_center (v_center),
    .out      (stg[0])
  );

  // Micro-rotation chain
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    uvpa_cordic_stage #(
      .STAGE(i)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .in (stg[i]),
      .out(stg[i+1])
    );
  end

  uvpa_finish #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_finish (
    .clk  (clk),
    .rst  (rst),
    .in   (stg[ITERATIONS]),
    .done (done),
    .phase(phase)
  );

  // Axis items around the last micro-rotation
  logic last_in_byp;
  logic last_out_byp;

  assign last_in_byp  = stg[ITERATIONS-1].valid && stg[ITERATIONS-1].byp;
  assign last_out_byp = stg[ITERATIONS].valid && stg[ITERATIONS].byp;

  `UVPA_ASSERT_HOLDS(a_top_sat, clk, rst, done, phase <= uvpa_pkg::top_code(ANGLE_FRAC_BITS))
  `UVPA_ASSERT_NEXT(a_top_axis, clk, rst, last_in_byp, last_out_byp)

endmodule

`default_nettype wire
